[design/microcoded_reverb_dsp_unit_macros.svh]
// Assertion macros shared by the reverb unit RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef MICROCODED_REVERB_DSP_UNIT_MACROS_SVH
`define MICROCODED_REVERB_DSP_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MRV_ASSERT_HOLDS(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MRV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/mrv_pkg.sv]
// Shared types and constants for the microcoded reverb unit.
// No dependencies; used by the interfaces and every module.
`timescale 1ns / 1ps

package mrv_pkg;

  localparam int RAM_DEPTH_DEF    = 16384;
  localparam int ROM_DEPTH_DEF    = 32768;
  localparam int STEPS_PER_SAMPLE = 64;
  localparam int STEP_W           = $clog2(STEPS_PER_SAMPLE);

  localparam int LAST_RIGHT_IN_STEP = 31;
  localparam int RIGHT_OUT_STEP     = 47;
  localparam int LEFT_OUT_STEP      = 56;

  localparam int PROG_AW  = 15;  // program byte address width
  localparam int OFFSET_W = 16;  // delay offset from two microcode bytes
  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 3;

  // microcode control byte bits
  localparam int CTL_SEL_INPUT = 0;  // write input sample instead of acc
  localparam int CTL_NO_WRITE  = 1;
  localparam int CTL_NO_LOAD   = 2;
  localparam int CTL_INVERT    = 3;
  localparam int CTL_KEEP_ACC  = 4;

  typedef enum logic [1:0] {
    CFG_EXT_MODES,
    CFG_MODE_SELECT,
    CFG_DELAY_TIME,
    CFG_LEVEL
  } cfg_idx_e;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef struct packed {
    logic                       req_type;
    logic [PROG_AW-1:0]         rom_addr;
    logic [7:0]                 rom_byte;
    logic signed [SAMPLE_W-1:0] in_left;
    logic signed [SAMPLE_W-1:0] in_right;
  } in_req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
  } out_res_t;

  // per-microstep control carried down the pipeline
  typedef struct packed {
    logic [7:0] ctl;
    logic [7:0] ctl2;
    logic       m1_lsb;
    logic       m2_lsb;
  } step_ctl_t;

endpackage

[design/mrv_stream_ifs.sv]
// Valid/ready request channels of the reverb unit.
// Depends on mrv_pkg for the payload types.
`timescale 1ns / 1ps

interface mrv_req_if;
  logic            valid;
  logic            ready;
  mrv_pkg::in_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mrv_res_if;
  logic             valid;
  logic             ready;
  mrv_pkg::out_res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/mrv_prog_rom.sv]
// Program store: byte-writable, read one 32-bit microstep word per cycle.
// Depends on mrv_pkg for address widths.
`timescale 1ns / 1ps

module mrv_prog_rom #(
  parameter int ROM_DEPTH = mrv_pkg::ROM_DEPTH_DEF  // bytes, multiple of four
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [mrv_pkg::PROG_AW-1:0] wr_addr_i,
  input  logic [7:0]                 wr_byte_i,
  input  logic [mrv_pkg::PROG_AW-1:0] rd_addr_i,
  output logic [31:0]                rd_word_o
);

  localparam int ROM_AW    = $clog2(ROM_DEPTH);
  localparam int ROM_WORDS = ROM_DEPTH / 4;
  localparam int WAW       = ROM_AW - 2;

  // byte address modulo depth; address is always below twice the depth
  function automatic logic [ROM_AW-1:0] wrap_addr(input logic [mrv_pkg::PROG_AW-1:0] a);
    logic [mrv_pkg::PROG_AW:0] t;
    t = {1'b0, a};
    if (t >= (mrv_pkg::PROG_AW + 1)'(ROM_DEPTH)) begin
      t = t - (mrv_pkg::PROG_AW + 1)'(ROM_DEPTH);
    end
    return t[ROM_AW-1:0];
  endfunction

  logic [31:0]       rom_mem [ROM_WORDS];
  logic [ROM_AW-1:0] wr_red;
  logic [ROM_AW-1:0] rd_red;
  logic [31:0]       rd_word_q;

  assign wr_red    = wrap_addr(wr_addr_i);
  assign rd_red    = wrap_addr(rd_addr_i);
  assign rd_word_o = rd_word_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      rom_mem[wr_red[ROM_AW-1:2]][{wr_red[1:0], 3'b000} +: 8] <= wr_byte_i;
    end
    rd_word_q <= rom_mem[rd_red[WAW+1:2]];
  end

endmodule

[design/mrv_alu.sv]
// Accumulator, shifter and carry with the two accumulate phases of a microstep.
// Depends on mrv_pkg for the step control struct.
`timescale 1ns / 1ps

module mrv_alu (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           exec_i,
  input  mrv_pkg::step_ctl_t             ctl_i,
  input  logic [3:0]                     saw_i,
  input  logic [mrv_pkg::SAMPLE_W-1:0]   ld_val_i,
  output logic [mrv_pkg::SAMPLE_W-1:0]   acc_o,
  output logic [mrv_pkg::SAMPLE_W-1:0]   acc_next_o
);

  localparam int W = mrv_pkg::SAMPLE_W;

  logic [W-1:0] acc_q, acc_d;
  logic [W-1:0] shift_q, shift_d;
  logic         carry_q, carry_d;

  always_comb begin
    logic         load;
    logic         c1;
    logic         c_mid;
    logic [W-1:0] a1;
    logic [W-1:0] a2;
    logic [W-1:0] sh_mid;

    load = !ctl_i.ctl[mrv_pkg::CTL_NO_LOAD];
    // a load clears carry before the first phase
    c1 = load ? 1'b0 : carry_q;

    a1 = ctl_i.ctl[mrv_pkg::CTL_KEEP_ACC] ? acc_q : '0;
    if (|({ctl_i.ctl[7:5], ctl_i.m1_lsb} & saw_i)) begin
      a1 = a1 + shift_q + {{(W-1){1'b0}}, c1};
    end
    if (ctl_i.ctl[mrv_pkg::CTL_INVERT]) begin
      a1 = ~a1;
    end

    sh_mid = load ? ld_val_i : {shift_q[W-1], shift_q[W-1:1]};
    c_mid  = load ? 1'b0 : (shift_q[W-1] & shift_q[0]);

    a2 = ctl_i.ctl2[mrv_pkg::CTL_KEEP_ACC] ? a1 : '0;
    if (|({ctl_i.ctl2[7:5], ctl_i.m2_lsb} & saw_i)) begin
      a2 = a2 + sh_mid + {{(W-1){1'b0}}, c_mid};
    end
    if (ctl_i.ctl2[mrv_pkg::CTL_INVERT]) begin
      a2 = ~a2;
    end

    if (exec_i) begin
      acc_d   = a2;
      shift_d = {sh_mid[W-1], sh_mid[W-1:1]};
      carry_d = sh_mid[W-1] & sh_mid[0];
    end else begin
      acc_d   = acc_q;
      shift_d = shift_q;
      carry_d = carry_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      shift_q <= '0;
      carry_q <= 1'b0;
    end else begin
      acc_q   <= acc_d;
      shift_q <= shift_d;
      carry_q <= carry_d;
    end
  end

  assign acc_o      = acc_q;
  assign acc_next_o = acc_d;

endmodule

[design/microcoded_reverb_dsp_unit.sv]
// Top level of the microcoded reverb unit: sequencer, delay RAM, result register.
// Depends on mrv_pkg, mrv_stream_ifs, mrv_prog_rom, mrv_alu and the macro header.
`timescale 1ns / 1ps

`include "microcoded_reverb_dsp_unit_macros.svh"

// Microcoded reverb unit. After reset the delay RAM is zeroed by a clearing
// pass over all RAM_DEPTH words (16384 by default); no request is taken until it
// ends, configuration writes are taken at any time. A load request writes one
// program byte and completes in the cycle it is accepted. A sample request
// runs 64 microsteps through a five-stage pipeline (program fetch, offset
// reduction, address add, delay RAM access, accumulate), one microstep per
// cycle; the result is offered once the last microstep has been accumulated
// and the result register is free, and no new request is taken before then.
// The delay RAM is single-port and serves one access per microstep.
// Microcode is four bytes per step, little-endian within a 32-bit program
// word, so ROM_DEPTH is a multiple of four. The user must write configuration
// only while no sample is in flight; the block itself does not enforce this.
module microcoded_reverb_dsp_unit #(
  parameter int RAM_DEPTH = mrv_pkg::RAM_DEPTH_DEF,
  parameter int ROM_DEPTH = mrv_pkg::ROM_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  mrv_req_if.sink                    req_i,
  mrv_res_if.source                  res_o,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [mrv_pkg::CFG_W-1:0]  cfg_wdata_i
);

  localparam int RAM_AW    = $clog2(RAM_DEPTH);
  localparam int OFF_SPAN  = 2 ** mrv_pkg::OFFSET_W;
  // conditional subtracts needed to bring a 16-bit offset below the depth
  localparam int RED_STEPS = $clog2((OFF_SPAN + RAM_DEPTH - 1) / RAM_DEPTH);
  localparam int STEP_W    = mrv_pkg::STEP_W;
  localparam int W         = mrv_pkg::SAMPLE_W;

  localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(mrv_pkg::STEPS_PER_SAMPLE - 1);
  localparam logic [STEP_W-1:0] R_OUT_STEP = STEP_W'(mrv_pkg::RIGHT_OUT_STEP);
  localparam logic [STEP_W-1:0] L_OUT_STEP = STEP_W'(mrv_pkg::LEFT_OUT_STEP);
  localparam logic [STEP_W-1:0] R_IN_LAST  = STEP_W'(mrv_pkg::LAST_RIGHT_IN_STEP);
  localparam logic [RAM_AW-1:0] RAM_LAST   = RAM_AW'(RAM_DEPTH - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_RUN,
    S_DONE
  } state_e;

  state_e state_q;

  // configuration
  logic       ext_modes_q;
  logic [2:0] mode_sel_q;
  logic [2:0] delay_time_q;
  logic [2:0] level_q;

  // control
  logic [RAM_AW-1:0] clr_q;
  logic [RAM_AW-1:0] wp_q;
  logic              fetch_act_q;
  logic [STEP_W-1:0] fetch_step_q;
  logic              v1_q, v2_q, v3_q, v4_q;
  logic              res_valid_q;

  // payload
  logic [W-1:0]        in_left_q, in_right_q;
  logic [STEP_W-1:0]   st1_q, st2_q, st3_q, st4_q;
  mrv_pkg::step_ctl_t  c2_q, c3_q, c4_q;
  logic [RAM_AW-1:0]   off_red_q;
  logic [RAM_AW-1:0]   addr3_q;
  logic [W-1:0]        wval4_q;
  logic                wr4_q;
  logic [W-1:0]        res_l_q, res_r_q;
  mrv_pkg::out_res_t   res_data_q;

  logic                        req_acc;
  logic                        res_load;
  logic                        rom_we;
  logic [2:0]                  mode;
  logic [3:0]                  saw;
  logic [mrv_pkg::PROG_AW-1:0] fetch_addr;
  logic [31:0]                 rom_word;
  logic [RAM_AW-1:0]           off_red_d;
  logic [RAM_AW-1:0]           addr3_d;
  logic [W-1:0]                in_sel;
  logic [W-1:0]                acc_q;
  logic [W-1:0]                acc_fwd;
  logic [W-1:0]                ld_val;
  logic                        ram_we;
  logic [RAM_AW-1:0]           ram_addr;
  logic [W-1:0]                ram_wdata;
  logic [W-1:0]                ram_rdata_q;
  logic [W-1:0]                ram_mem [RAM_DEPTH];

  assign req_acc     = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign rom_we      = req_acc && (req_i.data.req_type == mrv_pkg::REQ_LOAD);
  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_data_q;

  // finished sample moves into the result register once it is free
  assign res_load = (state_q == S_DONE) && (!res_valid_q || res_o.ready);

  // program base: mode in 14:12, level in 11:9, time bit 2 in bit 8
  assign mode       = ext_modes_q ? mode_sel_q : {1'b0, mode_sel_q[1:0]};
  assign saw        = 4'b0001 << delay_time_q[1:0];
  assign fetch_addr = {mode, level_q, delay_time_q[2], fetch_step_q, 2'b00};

  mrv_prog_rom #(
    .ROM_DEPTH (ROM_DEPTH)
  ) u_prog_rom (
    .clk_i     (clk_i),
    .we_i      (rom_we),
    .wr_addr_i (req_i.data.rom_addr),
    .wr_byte_i (req_i.data.rom_byte),
    .rd_addr_i (fetch_addr),
    .rd_word_o (rom_word)
  );

  // stage 1: offset {b2,b0} modulo RAM depth
  always_comb begin
    logic [mrv_pkg::OFFSET_W-1:0] off;
    off = {rom_word[23:16], rom_word[7:0]};
    for (int k = RED_STEPS - 1; k >= 0; k--) begin
      if (off >= mrv_pkg::OFFSET_W'(RAM_DEPTH << k)) begin
        off = off - mrv_pkg::OFFSET_W'(RAM_DEPTH << k);
      end
    end
    off_red_d = off[RAM_AW-1:0];
  end

  // stage 2: relative to the write position, wrapped
  always_comb begin
    logic [RAM_AW:0] sum;
    sum = {1'b0, wp_q} + {1'b0, off_red_q};
    if (sum >= (RAM_AW + 1)'(RAM_DEPTH)) begin
      sum = sum - (RAM_AW + 1)'(RAM_DEPTH);
    end
    addr3_d = sum[RAM_AW-1:0];
  end

  // stage 3: one RAM access; write data takes the accumulator result of the
  // step now in stage 4
  assign in_sel = (st3_q <= R_IN_LAST) ? in_right_q : in_left_q;

  always_comb begin
    ram_addr  = addr3_q;
    ram_we    = v3_q && !c3_q.ctl[mrv_pkg::CTL_NO_WRITE];
    ram_wdata = c3_q.ctl[mrv_pkg::CTL_SEL_INPUT] ? in_sel : acc_fwd;
    if (state_q == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_addr  = clr_q;
      ram_wdata = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      ram_mem[ram_addr] <= ram_wdata;
    end
    ram_rdata_q <= ram_mem[ram_addr];
  end

  // stage 4: accumulate
  assign ld_val = wr4_q ? wval4_q : ram_rdata_q;

  mrv_alu u_alu (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .exec_i     (v4_q),
    .ctl_i      (c4_q),
    .saw_i      (saw),
    .ld_val_i   (ld_val),
    .acc_o      (acc_q),
    .acc_next_o (acc_fwd)
  );

  // sequencer and result handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      wp_q         <= '0;
      fetch_act_q  <= 1'b0;
      fetch_step_q <= '0;
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      v3_q         <= 1'b0;
      v4_q         <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      v1_q <= fetch_act_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == RAM_LAST) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_acc && (req_i.data.req_type == mrv_pkg::REQ_SAMPLE)) begin
            state_q      <= S_RUN;
            fetch_act_q  <= 1'b1;
            fetch_step_q <= '0;
          end
        end
        S_RUN: begin
          if (fetch_act_q) begin
            fetch_step_q <= fetch_step_q + 1'b1;
            if (fetch_step_q == LAST_STEP) begin
              fetch_act_q <= 1'b0;
            end
          end
          if (v4_q && (st4_q == LAST_STEP)) begin
            state_q <= S_DONE;
            wp_q    <= (wp_q == RAM_LAST) ? '0 : wp_q + 1'b1;
          end
        end
        S_DONE: begin
          // hold here while the previous result is still unclaimed
          if (res_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      in_left_q  <= req_i.data.in_left;
      in_right_q <= req_i.data.in_right;
    end
    st1_q <= fetch_step_q;

    st2_q       <= st1_q;
    off_red_q   <= off_red_d;
    c2_q.ctl    <= rom_word[15:8];
    c2_q.ctl2   <= rom_word[31:24];
    c2_q.m1_lsb <= rom_word[23];
    c2_q.m2_lsb <= rom_word[22];

    st3_q   <= st2_q;
    c3_q    <= c2_q;
    addr3_q <= addr3_d;

    st4_q   <= st3_q;
    c4_q    <= c3_q;
    wval4_q <= ram_wdata;
    wr4_q   <= !c3_q.ctl[mrv_pkg::CTL_NO_WRITE];

    // outputs are the accumulator as it stands before the tap steps
    if (v4_q && (st4_q == R_OUT_STEP)) begin
      res_r_q <= acc_q;
    end
    if (v4_q && (st4_q == L_OUT_STEP)) begin
      res_l_q <= acc_q;
    end
    if (res_load) begin
      res_data_q.out_left  <= res_l_q;
      res_data_q.out_right <= res_r_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_modes_q  <= 1'b1;
      mode_sel_q   <= '0;
      delay_time_q <= '0;
      level_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mrv_pkg::CFG_EXT_MODES:   ext_modes_q  <= cfg_wdata_i[0];
        mrv_pkg::CFG_MODE_SELECT: mode_sel_q   <= cfg_wdata_i;
        mrv_pkg::CFG_DELAY_TIME:  delay_time_q <= cfg_wdata_i;
        mrv_pkg::CFG_LEVEL:       level_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // consecutive microsteps sit in the access and accumulate stages
  `MRV_ASSERT_HOLDS(a_step_order, clk_i, rst_ni, v3_q && v4_q, st3_q == st4_q + 1'b1, "microstep order broken between RAM access and accumulate")
  // nothing in flight once the sequencer is back to idle
  `MRV_ASSERT_HOLDS(a_idle_empty, clk_i, rst_ni, state_q == S_IDLE, !(fetch_act_q || v1_q || v2_q || v3_q || v4_q), "pipeline busy while idle")
  // a result appears only when a sample has finished
  `MRV_ASSERT_HOLDS(a_res_source, clk_i, rst_ni, $rose(res_valid_q), $past(state_q == S_DONE), "result raised without a finished sample")

endmodule
